// ===== src/hhef_pkg.sv =====
// Shared types, constants and helpers for the HTTP header end finder.
package hhef_pkg;

	// Default buffer size limit in bytes
	localparam int unsigned MAX_BUFFER_BYTES_DEF = 65535;

	// Buffers below this length are rejected
	localparam int unsigned MIN_BUFFER_BYTES = 16;

	// Length of the HTTP/ prefix
	localparam int unsigned PREFIX_LEN = 5;

	// Line break characters
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// Terminator lengths
	localparam logic [15:0] QUAD_TERM_LEN = 16'd4;
	localparam logic [15:0] PAIR_TERM_LEN = 16'd2;

	// Result status codes
	typedef enum logic [2:0] {
		ST_FOUND      = 3'd0,
		ST_SHORT      = 3'd1,
		ST_BAD_PREFIX = 3'd2,
		ST_NO_END     = 3'd3,
		ST_OVERFLOW   = 3'd4
	} status_t;

	// One result item passed to the output register
	typedef struct packed {
		status_t     status;
		logic [15:0] header_length;
		logic [15:0] data_offset;
		logic [15:0] data_length;
	} result_t;

	// Expected character of the prefix at a given position
	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0:    ch = 8'h48; // H
			3'd1:    ch = 8'h54; // T
			3'd2:    ch = 8'h54; // T
			3'd3:    ch = 8'h50; // P
			3'd4:    ch = 8'h2F; // slash
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Map lower-case letters to upper case
	function automatic logic [7:0] fold_upper(input logic [7:0] ch);
		logic [7:0] r;
		if (ch >= 8'h61 && ch <= 8'h7A) begin
			r = ch - 8'h20;
		end else begin
			r = ch;
		end
		return r;
	endfunction

endpackage

// ===== src/http_header_end_finder.sv =====
// HTTP header end finder: input register, byte scanner, result register.
// Result path: the last byte passes the input register, then the result register, whose load raises result valid.
// Throughput: one byte per cycle while byte_stall is low; the scanner updates its state once per byte.
// A non-last byte moves on even while a result waits; only a last byte waits for the slot.
// Reset (arst_n low, asynchronous) empties both registers and returns the scan state
// to its start; the same state is restored after every last byte.
module http_header_end_finder #(
	parameter int unsigned MAX_BUFFER_BYTES = hhef_pkg::MAX_BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic [15:0] header_length,
	output logic [15:0] data_offset,
	output logic [15:0] data_length
);
	import hhef_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       accept;
	logic       s1_move;
	logic       out_free;
	result_t    res;

	// Stage 1 moves on unless its last byte finds the result slot full
	assign s1_move    = valid_s1 && (!last_s1 || out_free);
	assign byte_stall = valid_s1 && !s1_move;
	assign accept     = byte_valid && !byte_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
		end
	end

	hhef_scan #(
		.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (s1_move),
		.byte_value (byte_s1),
		.last_byte  (last_s1),
		.res        (res)
	);

	hhef_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (s1_move && last_s1),
		.res           (res),
		.free          (out_free),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.status        (status),
		.header_length (header_length),
		.data_offset   (data_offset),
		.data_length   (data_length)
	);

endmodule

// ===== src/hhef_scan.sv =====
// Byte scanner: prefix check, terminator search and final result computation.
module hhef_scan #(
	parameter int unsigned MAX_BUFFER_BYTES = hhef_pkg::MAX_BUFFER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_value,
	input  logic              last_byte,
	output hhef_pkg::result_t res
);
	import hhef_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_BUFFER_BYTES + 2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BUFFER_BYTES);
	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_BUFFER_BYTES + 1);

	logic [CNT_W-1:0] byte_count_q, byte_count_d;
	logic [23:0]      recent_bytes_q, recent_bytes_d;
	logic             prefix_good_q, prefix_good_d;
	logic [CNT_W-1:0] crlf_pair_start_q, crlf_pair_start_d;
	logic             crlf_pair_seen_q, crlf_pair_seen_d;
	logic [CNT_W-1:0] double_lf_start_q, double_lf_start_d;
	logic             double_lf_seen_q, double_lf_seen_d;
	logic [CNT_W-1:0] lfcr_pair_start_q, lfcr_pair_start_d;
	logic             lfcr_pair_seen_q, lfcr_pair_seen_d;

	logic [7:0] b1, b2, b3;
	logic       scan_en;
	logic       ge1, ge3;
	logic [15:0] len16, hlen16, term_len;

	assign b1 = recent_bytes_q[7:0];
	assign b2 = recent_bytes_q[15:8];
	assign b3 = recent_bytes_q[23:16];
	assign scan_en = byte_count_q < CNT_MAX;
	assign ge1 = byte_count_q >= CNT_W'(1);
	assign ge3 = byte_count_q >= CNT_W'(3);

	// Next scan state for the byte in hand
	always_comb begin
		byte_count_d      = byte_count_q;
		recent_bytes_d    = recent_bytes_q;
		prefix_good_d     = prefix_good_q;
		crlf_pair_start_d = crlf_pair_start_q;
		crlf_pair_seen_d  = crlf_pair_seen_q;
		double_lf_start_d = double_lf_start_q;
		double_lf_seen_d  = double_lf_seen_q;
		lfcr_pair_start_d = lfcr_pair_start_q;
		lfcr_pair_seen_d  = lfcr_pair_seen_q;
		if (scan_en) begin
			if (byte_count_q < CNT_W'(PREFIX_LEN) &&
				fold_upper(byte_value) != prefix_char(byte_count_q[2:0])) begin
				prefix_good_d = 1'b0;
			end
			if (!crlf_pair_seen_q && ge3 && b3 == CH_CR && b2 == CH_LF &&
				b1 == CH_CR && byte_value == CH_LF) begin
				crlf_pair_seen_d  = 1'b1;
				crlf_pair_start_d = byte_count_q - CNT_W'(3);
			end
			if (!double_lf_seen_q && ge1 && b1 == CH_LF && byte_value == CH_LF) begin
				double_lf_seen_d  = 1'b1;
				double_lf_start_d = byte_count_q - CNT_W'(1);
			end
			if (!lfcr_pair_seen_q && ge3 && b3 == CH_LF && b2 == CH_CR &&
				b1 == CH_LF && byte_value == CH_CR) begin
				lfcr_pair_seen_d  = 1'b1;
				lfcr_pair_start_d = byte_count_q - CNT_W'(3);
			end
			recent_bytes_d = {recent_bytes_q[15:0], byte_value};
			byte_count_d   = byte_count_q + CNT_W'(1);
		end else begin
			byte_count_d = CNT_SAT;
		end
	end

	// Final result from the state after this byte; priority is fixed
	always_comb begin
		res      = '0;
		len16    = 16'(byte_count_d);
		hlen16   = '0;
		term_len = '0;
		if (byte_count_d > CNT_MAX) begin
			res.status = ST_OVERFLOW;
		end else if (byte_count_d < CNT_W'(MIN_BUFFER_BYTES)) begin
			res.status = ST_SHORT;
		end else if (!prefix_good_d) begin
			res.status = ST_BAD_PREFIX;
		end else if (crlf_pair_seen_d) begin
			res.status = ST_FOUND;
			hlen16     = 16'(crlf_pair_start_d);
			term_len   = QUAD_TERM_LEN;
		end else if (double_lf_seen_d) begin
			res.status = ST_FOUND;
			hlen16     = 16'(double_lf_start_d);
			term_len   = PAIR_TERM_LEN;
		end else if (lfcr_pair_seen_d) begin
			res.status = ST_FOUND;
			hlen16     = 16'(lfcr_pair_start_d);
			term_len   = QUAD_TERM_LEN;
		end else begin
			res.status = ST_NO_END;
		end
		if (res.status == ST_FOUND) begin
			res.header_length = hlen16;
			res.data_offset   = hlen16 + term_len;
			res.data_length   = len16 - hlen16 - term_len;
		end
	end

	// State registers; cleared after the last byte of a buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q      <= '0;
			recent_bytes_q    <= '0;
			prefix_good_q     <= 1'b1;
			crlf_pair_start_q <= '0;
			crlf_pair_seen_q  <= 1'b0;
			double_lf_start_q <= '0;
			double_lf_seen_q  <= 1'b0;
			lfcr_pair_start_q <= '0;
			lfcr_pair_seen_q  <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				byte_count_q      <= '0;
				recent_bytes_q    <= '0;
				prefix_good_q     <= 1'b1;
				crlf_pair_start_q <= '0;
				crlf_pair_seen_q  <= 1'b0;
				double_lf_start_q <= '0;
				double_lf_seen_q  <= 1'b0;
				lfcr_pair_start_q <= '0;
				lfcr_pair_seen_q  <= 1'b0;
			end else begin
				byte_count_q      <= byte_count_d;
				recent_bytes_q    <= recent_bytes_d;
				prefix_good_q     <= prefix_good_d;
				crlf_pair_start_q <= crlf_pair_start_d;
				crlf_pair_seen_q  <= crlf_pair_seen_d;
				double_lf_start_q <= double_lf_start_d;
				double_lf_seen_q  <= double_lf_seen_d;
				lfcr_pair_start_q <= lfcr_pair_start_d;
				lfcr_pair_seen_q  <= lfcr_pair_seen_d;
			end
		end
	end

endmodule

// ===== src/hhef_out.sv =====
// Result register with valid/stall handshake toward the consumer.
module hhef_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  hhef_pkg::result_t res,
	output logic              free,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [2:0]        status,
	output logic [15:0]       header_length,
	output logic [15:0]       data_offset,
	output logic [15:0]       data_length
);
	import hhef_pkg::*;

	logic    valid_q;
	result_t res_q;

	// Slot can take a new result when empty or draining this cycle
	assign free = !valid_q || !result_stall;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload, held while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign result_valid  = valid_q;
	assign status        = res_q.status;
	assign header_length = res_q.header_length;
	assign data_offset   = res_q.data_offset;
	assign data_length   = res_q.data_length;

endmodule

// ===== test/http_header_end_finder_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the HTTP header end finder: directed and random buffers.
module http_header_end_finder_test;
	import hhef_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 10;
	localparam int RANDOM_BYTES = 1000;
	localparam int RANDOM_BUFS  = 24;

	typedef bit [7:0] octet_q[$];

	// Tracks the scan state of the current buffer and the results it must give
	class header_end_scoreboard;
		int unsigned byte_total;
		bit [23:0]   last_three;
		bit          prefix_ok;
		bit [15:0]   crlf_at, lflf_at, lfcr_at;
		bit          crlf_hit, lflf_hit, lfcr_hit;
		result_t     expected_results[$];
		int          mismatches;
		int          results_seen;
		int          status_seen[5];

		function new();
			rewind();
		endfunction

		function void rewind();
			byte_total = 0;
			last_three = '0;
			prefix_ok  = 1'b1;
			crlf_at    = '0;
			lflf_at    = '0;
			lfcr_at    = '0;
			crlf_hit   = 1'b0;
			lflf_hit   = 1'b0;
			lfcr_hit   = 1'b0;
		endfunction

		static function bit [7:0] to_upper(bit [7:0] c);
			return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Advance the scan by one accepted byte; on the last byte queue the result
		function void note_byte(bit [7:0] b, bit last);
			string       want = "HTTP/";
			result_t     r;
			int unsigned idx;
			int unsigned term_len;
			int unsigned hdr;
			if (byte_total < MAX_BUFFER_BYTES_DEF) begin
				idx = byte_total;
				if (idx < PREFIX_LEN && to_upper(b) != want[idx])
					prefix_ok = 1'b0;
				if (!crlf_hit && idx >= 3 && last_three == {CH_CR, CH_LF, CH_CR} && b == CH_LF) begin
					crlf_hit = 1'b1;
					crlf_at  = 16'(idx - 3);
				end
				if (!lflf_hit && idx >= 1 && last_three[7:0] == CH_LF && b == CH_LF) begin
					lflf_hit = 1'b1;
					lflf_at  = 16'(idx - 1);
				end
				if (!lfcr_hit && idx >= 3 && last_three == {CH_LF, CH_CR, CH_LF} && b == CH_CR) begin
					lfcr_hit = 1'b1;
					lfcr_at  = 16'(idx - 3);
				end
				last_three = {last_three[15:0], b};
				byte_total = idx + 1;
			end else begin
				byte_total = MAX_BUFFER_BYTES_DEF + 1;
			end
			if (!last)
				return;

			// Status by priority; terminator by pattern priority
			r = '0;
			term_len = 0;
			hdr = 0;
			if (byte_total > MAX_BUFFER_BYTES_DEF) begin
				r.status = ST_OVERFLOW;
			end else if (byte_total < MIN_BUFFER_BYTES) begin
				r.status = ST_SHORT;
			end else if (!prefix_ok) begin
				r.status = ST_BAD_PREFIX;
			end else if (crlf_hit) begin
				r.status = ST_FOUND;
				hdr = 32'(crlf_at);
				term_len = 4;
			end else if (lflf_hit) begin
				r.status = ST_FOUND;
				hdr = 32'(lflf_at);
				term_len = 2;
			end else if (lfcr_hit) begin
				r.status = ST_FOUND;
				hdr = 32'(lfcr_at);
				term_len = 4;
			end else begin
				r.status = ST_NO_END;
			end
			if (r.status == ST_FOUND) begin
				r.header_length = 16'(hdr);
				r.data_offset   = 16'(hdr + term_len);
				r.data_length   = 16'(byte_total - hdr - term_len);
			end
			expected_results.push_back(r);
			rewind();
		endfunction

		task report_mismatch(string msg);
			if (mismatches < 100)
				$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		// Compare one result transfer with the oldest expectation
		task check_result(logic [2:0] st, logic [15:0] hl, logic [15:0] off, logic [15:0] dl);
			result_t due;
			results_seen++;
			if (st < 5)
				status_seen[st]++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %0d not expected (status %0d)", results_seen, st));
				return;
			end
			due = expected_results.pop_front();
			if (st !== due.status)
				report_mismatch($sformatf("result %0d status %0d, want %s",
					results_seen, st, due.status.name()));
			if (hl !== due.header_length)
				report_mismatch($sformatf("result %0d header_length %0d, want %0d",
					results_seen, hl, due.header_length));
			if (off !== due.data_offset)
				report_mismatch($sformatf("result %0d data_offset %0d, want %0d",
					results_seen, off, due.data_offset));
			if (dl !== due.data_length)
				report_mismatch($sformatf("result %0d data_length %0d, want %0d",
					results_seen, dl, due.data_length));
		endtask

		task report_leftovers();
			if (expected_results.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  byte_value = 8'h00;
	logic        last_byte = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  status;
	logic [15:0] header_length;
	logic [15:0] data_offset;
	logic [15:0] data_length;

	header_end_scoreboard sb = new();
	int idle_pct = 22;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int cycles = 0;
	int bytes_sent = 0;
	int buffers_sent = 0;

	http_header_end_finder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_value   (byte_value),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.header_length(header_length),
		.data_offset  (data_offset),
		.data_length  (data_length)
	);

	always #CLK_HALF clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: check each transfer, then pick the next stall value
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(status, header_length, data_offset, data_length);
		if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// One byte transfer, with random idle cycles ahead of it
	task automatic send_byte(input bit [7:0] b, input bit last);
		while ($urandom_range(99) < idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_value <= b;
		last_byte  <= last;
		do @(posedge clk); while (byte_stall);
		sb.note_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_buffer(ref octet_q msg);
		foreach (msg[i])
			send_byte(msg[i], i == msg.size() - 1);
		buffers_sent++;
	endtask

	// Sender goes quiet until every result has come back
	task automatic wait_drained();
		byte_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic void add_text(ref octet_q msg, input string s);
		for (int i = 0; i < s.len(); i++)
			msg.push_back(s[i]);
	endfunction

	// Line breaks spelled as r (CR) and n (LF)
	function automatic void add_breaks(ref octet_q msg, input string code);
		for (int i = 0; i < code.len(); i++)
			msg.push_back(code[i] == "r" ? CH_CR : CH_LF);
	endfunction

	// Prefix with random letter case; a bad one gets one position spoiled
	function automatic void add_prefix(ref octet_q msg, input bit good);
		string     want = "HTTP/";
		int        base;
		int        pos;
		bit [7:0]  c;
		base = msg.size();
		for (int i = 0; i < PREFIX_LEN; i++) begin
			c = want[i];
			if (c != "/" && $urandom_range(1))
				c = c + 8'h20;
			msg.push_back(c);
		end
		if (!good) begin
			pos = $urandom_range(PREFIX_LEN - 1);
			do c = 8'($urandom_range(255)); while (header_end_scoreboard::to_upper(c) == want[pos]);
			msg[base + pos] = c;
		end
	endfunction

	// Header-like filler, rich in CR and, if allowed, LF
	function automatic void add_filler(ref octet_q msg, input int n, input bit allow_lf);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 12)
				msg.push_back(CH_CR);
			else if (r < 24 && allow_lf)
				msg.push_back(CH_LF);
			else if (r < 32)
				msg.push_back(allow_lf ? 8'($urandom_range(255)) : 8'h00);
			else
				msg.push_back(8'($urandom_range(32, 126)));
		end
	endfunction

	function automatic void add_terminator(ref octet_q msg);
		case ($urandom_range(5))
			0: add_breaks(msg, "rnrn");
			1: add_breaks(msg, "nn");
			2: add_breaks(msg, "nrnr");
			3: add_breaks(msg, "nrnrn");
			4: begin
				add_breaks(msg, "nn");
				add_filler(msg, $urandom_range(0, 4), 1'b0);
				add_breaks(msg, "rnrn");
			end
			default: begin
				add_breaks(msg, "nrnr");
				add_filler(msg, $urandom_range(0, 3), 1'b0);
				add_breaks(msg, "nn");
			end
		endcase
	endfunction

	// Half well-formed responses; the rest broken or plain noise
	function automatic void make_random_buffer(ref octet_q msg);
		int kind;
		int keep;
		msg.delete();
		kind = $urandom_range(99);
		if (kind < 70) begin
			add_prefix(msg, kind >= 60 && kind < 70 ? 1'b0 : 1'b1);
			if (kind >= 50 && kind < 60) begin
				add_filler(msg, $urandom_range(6, 35), 1'b0);
			end else begin
				add_filler(msg, $urandom_range(6, 30), 1'($urandom_range(1)));
				add_terminator(msg);
				add_filler(msg, $urandom_range(0, 20), 1'b1);
			end
		end else if (kind < 80) begin
			add_prefix(msg, 1'b1);
			add_filler(msg, 4, 1'b1);
			add_breaks(msg, "rnrn");
			add_filler(msg, 4, 1'b1);
			keep = $urandom_range(1, MIN_BUFFER_BYTES - 1);
			while (msg.size() > keep)
				void'(msg.pop_back());
		end else begin
			repeat ($urandom_range(1, 80))
				msg.push_back(8'($urandom_range(255)));
		end
	endfunction

	initial begin
		octet_q msg;
		int     rand_bytes;
		int     nb;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single byte, each terminator, priorities, NUL bytes, no end, short, bad prefix
		msg = {8'hFF};
		send_buffer(msg);
		msg.delete(); add_text(msg, "HTTP/1.1 200 OK"); add_breaks(msg, "rnrn");
		send_buffer(msg);
		msg.delete(); add_text(msg, "http/1.0 2"); msg.push_back(8'h00); msg.push_back(8'h00);
		add_breaks(msg, "nn"); add_text(msg, "xy");
		send_buffer(msg);
		// LF CR LF CR overlaps an earlier-priority CR LF CR LF
		msg.delete(); add_text(msg, "HTTP/1.1 x"); add_breaks(msg, "nrnrn"); add_text(msg, "body");
		send_buffer(msg);
		// LF LF comes first but CR LF CR LF wins
		msg.delete(); add_text(msg, "HTTP/ a"); add_breaks(msg, "nn"); add_text(msg, "b");
		add_breaks(msg, "rnrn"); add_text(msg, "zz");
		send_buffer(msg);
		msg.delete(); add_text(msg, "HTTP/1.1 ok"); add_breaks(msg, "nrnr"); add_text(msg, "body");
		send_buffer(msg);
		// Terminator completes on the last byte, exactly 16 bytes
		msg.delete(); add_text(msg, "HTtP/1.1 end"); add_breaks(msg, "rnrn");
		send_buffer(msg);
		msg.delete(); add_text(msg, "HTTQ/1.1 200"); add_breaks(msg, "rnrn");
		send_buffer(msg);
		msg.delete(); add_text(msg, "HTTP/1.1 200 OK"); add_breaks(msg, "rnr"); add_text(msg, "x");
		send_buffer(msg);
		// Bad prefix in a short buffer reports short
		msg.delete(); add_text(msg, "Xttp/"); add_breaks(msg, "rnrn");
		send_buffer(msg);

		// Random buffers, with a no-idle stretch, a long result hold-off and a drain pause
		rand_bytes = 0;
		for (nb = 0; rand_bytes < RANDOM_BYTES || nb < RANDOM_BUFS; nb++) begin
			idle_pct = (nb >= 5 && nb < 12) ? 0 : 22;
			if (nb == 15)
				hold_requests++;
			if (nb == 22)
				wait_drained();
			make_random_buffer(msg);
			rand_bytes += msg.size();
			send_buffer(msg);
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		sb.report_leftovers();

		$display("Sent %0d buffers, %0d bytes, in %0d cycles; %0d results checked.",
			buffers_sent, bytes_sent, cycles, sb.results_seen);
		$display("Status mix: found %0d, short %0d, bad prefix %0d, no end %0d, overflow %0d.",
			sb.status_seen[ST_FOUND], sb.status_seen[ST_SHORT], sb.status_seen[ST_BAD_PREFIX],
			sb.status_seen[ST_NO_END], sb.status_seen[ST_OVERFLOW]);
		if (sb.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== http_header_end_finder.f =====
src/hhef_pkg.sv
src/hhef_scan.sv
src/hhef_out.sv
src/http_header_end_finder.sv
test/http_header_end_finder_test.sv
